// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising edge of clk, disabled while rst_n is low.
`define MAHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on the rising edge of clk, disabled while rst_n is low.
`define MAHS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mahs_pkg.sv
package mahs_pkg;

  localparam int JOINTS = 6;
  localparam logic [2:0] LAST_JOINT = 3'(JOINTS - 1);
  localparam logic [3:0] JOINT_COUNT = 4'(JOINTS);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [19:0] SEEK_DIST_RST = 20'd100000;

  localparam logic [1:0] REG_DIR_MASK      = 2'd0;
  localparam logic [1:0] REG_SEEK_DIST     = 2'd1;
  localparam logic [1:0] REG_BACKOFF_BASE  = 2'd2;
  localparam logic [1:0] REG_BACKOFF_OTHER = 2'd3;

  typedef enum logic [1:0] {
    FN_TICK      = 2'd0,
    FN_START_ALL = 2'd1,
    FN_START_ONE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_FAST = 3'd1,
    PH_BACK = 3'd2,
    PH_SLOW = 3'd3,
    PH_ZERO = 3'd4,
    PH_DONE = 3'd5,
    PH_FAIL = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_SEEK_FAST = 3'd1,
    CMD_BACKOFF   = 3'd2,
    CMD_SEEK_SLOW = 3'd3,
    CMD_STOP      = 3'd4,
    CMD_ZERO      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    PROF_FAST_HOME = 2'd0,
    PROF_SLOW_HOME = 2'd1,
    PROF_OP_BASE   = 2'd2,
    PROF_OP_OTHER  = 2'd3
  } prof_t;

  typedef struct packed {
    cmd_t               command;
    logic [2:0]         cmd_joint;
    logic signed [20:0] move_offset;
    prof_t              speed_profile;
    phase_t             phase_now;
    logic               active;
    logic               succeeded;
    logic               last;
  } res_t;

  function automatic logic signed [20:0] signed_ofs(logic [19:0] mag, logic neg);
    logic [20:0] m;
    m = {1'b0, mag};
    return neg ? $signed(-m) : $signed(m);
  endfunction

  function automatic res_t mk_res(cmd_t cmd, logic [2:0] joint, logic signed [20:0] ofs,
                                  prof_t prof, phase_t ph, logic succ, logic last);
    res_t r;
    r.command       = cmd;
    r.cmd_joint     = joint;
    r.move_offset   = ofs;
    r.speed_profile = prof;
    r.phase_now     = ph;
    r.active        = (ph == PH_FAST) || (ph == PH_BACK) || (ph == PH_SLOW) ||
                      (ph == PH_ZERO);
    r.succeeded     = succ;
    r.last          = last;
    return r;
  endfunction

endpackage

// File: rtl/core/multi_axis_homing_sequencer.sv
// Two-pass limit-switch homing sequencer for up to six axes.
// Throughput: one item per cycle while in_stall is low; the four-entry result queue
// drains one result per cycle unless out_stall is high. Results are queued when
// their item is accepted; a zero step chaining into the next joint makes two results.
// Reset (synchronous, rst_n low): phase idle, joint 0, flags clear, registers to
// their defaults and the result queue empty.
module multi_axis_homing_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_joint,
  input  logic [5:0]         in_limit_switches_n,
  input  logic               in_motion_busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_command,
  output logic [2:0]         out_cmd_joint,
  output logic signed [20:0] out_move_offset,
  output logic [1:0]         out_speed_profile,
  output logic [2:0]         out_phase_now,
  output logic               out_active,
  output logic               out_succeeded,
  output logic               out_last
);
  import mahs_pkg::*;

  logic [5:0]  dir_mask_r;
  logic [19:0] seek_dist_r;
  logic [15:0] bo_base_r;
  logic [15:0] bo_other_r;

  phase_t     phase_r, phase_nxt;
  logic [2:0] joint_r, joint_nxt;
  logic       all_r, all_nxt;
  logic       succ_r, succ_nxt;

  res_t res0, res1;
  logic two;

  res_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  logic       accept, pop;
  logic [7:0] mask8, sw8;
  logic       neg, hit, neg_next;
  logic [2:0] jnext;
  logic [15:0] bo;
  prof_t      op_prof;

  assign in_stall  = cnt_r > QCNT_W'(QDEPTH - 2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && !out_stall;

  assign mask8    = {2'b00, dir_mask_r};
  assign sw8      = {2'b11, in_limit_switches_n};
  assign neg      = mask8[joint_r];
  assign hit      = !sw8[joint_r];
  assign jnext    = joint_r + 3'd1;
  assign neg_next = mask8[jnext];
  assign bo       = (joint_r < 3'd2) ? bo_base_r : bo_other_r;
  assign op_prof  = (joint_r < 3'd2) ? PROF_OP_BASE : PROF_OP_OTHER;

  always_comb begin
    phase_nxt = phase_r;
    joint_nxt = joint_r;
    all_nxt   = all_r;
    succ_nxt  = succ_r;
    two       = 1'b0;
    res0      = mk_res(CMD_NONE, joint_r, '0, PROF_FAST_HOME, phase_r, succ_r, 1'b1);
    res1      = res0;
    case (in_func)
      FN_START_ALL: begin
        all_nxt   = 1'b1;
        succ_nxt  = 1'b0;
        joint_nxt = 3'd0;
        phase_nxt = PH_FAST;
        res0 = mk_res(CMD_SEEK_FAST, 3'd0, signed_ofs(seek_dist_r, mask8[0]),
                      PROF_FAST_HOME, PH_FAST, 1'b0, 1'b1);
      end
      FN_START_ONE: begin
        if ({1'b0, in_joint} < JOINT_COUNT) begin
          all_nxt   = 1'b0;
          succ_nxt  = 1'b0;
          joint_nxt = in_joint;
          phase_nxt = PH_FAST;
          res0 = mk_res(CMD_SEEK_FAST, in_joint, signed_ofs(seek_dist_r, mask8[in_joint]),
                        PROF_FAST_HOME, PH_FAST, 1'b0, 1'b1);
        end
      end
      FN_TICK: begin
        case (phase_r)
          PH_FAST: begin
            if (hit) begin
              phase_nxt = PH_BACK;
              res0 = mk_res(CMD_BACKOFF, joint_r, signed_ofs({4'd0, bo}, !neg),
                            PROF_FAST_HOME, PH_BACK, succ_r, 1'b1);
            end else if (!in_motion_busy) begin
              phase_nxt = PH_FAIL;
              res0 = mk_res(CMD_NONE, joint_r, '0, PROF_FAST_HOME, PH_FAIL, succ_r, 1'b1);
            end
          end
          PH_BACK: begin
            if (!in_motion_busy) begin
              phase_nxt = PH_SLOW;
              res0 = mk_res(CMD_SEEK_SLOW, joint_r, signed_ofs(seek_dist_r, neg),
                            PROF_SLOW_HOME, PH_SLOW, succ_r, 1'b1);
            end
          end
          PH_SLOW: begin
            if (hit) begin
              phase_nxt = PH_ZERO;
              res0 = mk_res(CMD_STOP, joint_r, '0, PROF_SLOW_HOME, PH_ZERO, succ_r, 1'b1);
            end else if (!in_motion_busy) begin
              phase_nxt = PH_FAIL;
              res0 = mk_res(CMD_NONE, joint_r, '0, PROF_FAST_HOME, PH_FAIL, succ_r, 1'b1);
            end
          end
          PH_ZERO: begin
            if (!all_r || joint_r >= LAST_JOINT) begin
              phase_nxt = PH_DONE;
              succ_nxt  = 1'b1;
              res0 = mk_res(CMD_ZERO, joint_r, '0, op_prof, PH_DONE, 1'b1, 1'b1);
            end else begin
              two       = 1'b1;
              joint_nxt = jnext;
              phase_nxt = PH_FAST;
              res0 = mk_res(CMD_ZERO, joint_r, '0, op_prof, PH_ZERO, succ_r, 1'b0);
              res1 = mk_res(CMD_SEEK_FAST, jnext, signed_ofs(seek_dist_r, neg_next),
                            PROF_FAST_HOME, PH_FAST, succ_r, 1'b1);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cnt_nxt + QCNT_W'(1) + QCNT_W'(two);
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_mask_r  <= '0;
      seek_dist_r <= SEEK_DIST_RST;
      bo_base_r   <= '0;
      bo_other_r  <= '0;
      phase_r     <= PH_IDLE;
      joint_r     <= '0;
      all_r       <= 1'b0;
      succ_r      <= 1'b0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DIR_MASK:      dir_mask_r  <= cfg_wdata[5:0];
          REG_SEEK_DIST:     seek_dist_r <= cfg_wdata;
          REG_BACKOFF_BASE:  bo_base_r   <= cfg_wdata[15:0];
          REG_BACKOFF_OTHER: bo_other_r  <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_r  <= phase_nxt;
        joint_r  <= joint_nxt;
        all_r    <= all_nxt;
        succ_r   <= succ_nxt;
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1) + QPTR_W'(two);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_ptr_r] <= res0;
      if (two) begin
        q_r[wr_ptr_r + QPTR_W'(1)] <= res1;
      end
    end
  end

  assign out_command       = q_r[rd_ptr_r].command;
  assign out_cmd_joint     = q_r[rd_ptr_r].cmd_joint;
  assign out_move_offset   = q_r[rd_ptr_r].move_offset;
  assign out_speed_profile = q_r[rd_ptr_r].speed_profile;
  assign out_phase_now     = q_r[rd_ptr_r].phase_now;
  assign out_active        = q_r[rd_ptr_r].active;
  assign out_succeeded     = q_r[rd_ptr_r].succeeded;
  assign out_last          = q_r[rd_ptr_r].last;

endmodule

// File: rtl/core/mahs_checker.sv
`include "assert_macros.svh"

module mahs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_command,
  input logic signed [20:0] out_move_offset,
  input logic               out_succeeded,
  input logic               out_last
);
  import mahs_pkg::*;

  `MAHS_ASSERT_IMP(a_item_gives_result, in_valid && !in_stall, out_valid,
    "accepted item produced no result")
  `MAHS_ASSERT_IMP(a_second_result_ready, out_valid && !out_stall && !out_last, out_valid,
    "second result of an item was not ready behind the first")
  `MAHS_ASSERT_IMP(a_stalled_out_holds, out_valid && out_stall,
    out_valid && $stable(out_command) && $stable(out_move_offset) && $stable(out_last),
    "stalled result changed")
  `MAHS_ASSERT(a_done_means_success,
    (out_valid && out_command == CMD_ZERO && out_last) |-> out_succeeded,
    "completed homing run not reported as successful")

endmodule

bind multi_axis_homing_sequencer mahs_checker u_mahs_checker (.*);
